FILE: rtl/lru_key_value_cache_unit_macros.svh
// Assertion macros used by the cache top level.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define LKVC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lkvc_pkg.sv
// Types and constants shared by the cache cells and the cache top level.
package lkvc_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic any_hit;
		logic insert;
		logic room;
	} ctrl_t;

endpackage

FILE: rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative key/value cache with least-recently-used replacement.
//
// Input channel (in_valid/in_ready) carries operation, key and value; a get looks up
// the key, a put inserts or updates it. Output channel (out_valid/out_ready) returns
// one transaction per input: hit, and read_value for a get that hits (zero otherwise).
// cfg_we/cfg_wdata set the capacity in use; write it only while the cache is idle.
// Entries sit in a chain of cells ordered by recency: cell 0 is the most recent.
// The key is compared in every cell at the edge that accepts the input; the update
// then moves cells back along the chain and loads cell 0 with the used entry.
// The result is registered at the update, and no new operation is taken until the
// update of the last one is done: each compare step is followed by an update step.
// A result waits in the output register while the receiver stalls; the next input is
// still accepted and compared, and its update waits until the output register frees.
// Reset empties the cache at once and sets the capacity to 16 entries.
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic signed [lkvc_pkg::KEY_W-1:0] key,
	input  logic signed [lkvc_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
	import lkvc_pkg::*;

	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > CAP_W) ? UW : CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t              state_q, state_d;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       used_q;
	logic [CW-1:0]       cap_ext;
	logic [CW-1:0]       eff_cap;
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   value_q;
	logic                out_valid_q;
	logic                hit_q;
	logic [DATA_W-1:0]   rdata_q;
	ctrl_t               ctrl;
	entry_t [ENTRIES:0]  ent;
	logic [ENTRIES:0]    tail;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  valid_vec;
	logic [DATA_W-1:0]   hit_data;
	logic                accept;

	assign accept   = in_valid & in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign cap_ext = CW'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign ctrl.capture = accept;
	assign ctrl.exec    = (state_q == ST_EXEC) & (~out_valid_q | out_ready);
	assign ctrl.any_hit = tail[0];
	assign ctrl.insert  = (op_q == OP_PUT) & ~tail[0];
	assign ctrl.room    = (used_q < eff_cap);

	always_comb begin
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_data = hit_data | ent[i + 1].data;
			end
		end
	end

	assign ent[0].valid = 1'b1;
	assign ent[0].key   = key_q;
	assign ent[0].data  = (op_q == OP_PUT) ? value_q : hit_data;
	assign tail[ENTRIES] = 1'b0;

	genvar gi;
	for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
		lkvc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.probe_key (key),
			.prev      (ent[gi]),
			.tail_in   (tail[gi + 1]),
			.cur       (ent[gi + 1]),
			.match     (match[gi]),
			.tail_out  (tail[gi])
		);
		assign valid_vec[gi] = ent[gi + 1].valid;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (ctrl.exec) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctrl.exec && ctrl.insert && ctrl.room) begin
				used_q <= used_q + CW'(1);
			end
			if (ctrl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(operation);
			key_q   <= key;
			value_q <= value;
		end
		if (ctrl.exec) begin
			hit_q   <= ctrl.any_hit;
			rdata_q <= (ctrl.any_hit && op_q == OP_GET) ? hit_data : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = $signed(rdata_q);

	`LKVC_ASSERT_IMP(a_match_unique, state_q == ST_EXEC, $onehot0(match), "Key matched twice.")
	`LKVC_ASSERT_IMP(a_valid_packed, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "Gap in cells.")
	`LKVC_ASSERT_IMP(a_used_count, 1'b1, $countones(valid_vec) == used_q, "Entry count is off.")
	`LKVC_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "Update cycle was skipped.")

endmodule

FILE: rtl/lkvc_cell.sv
// One recency-ordered cache cell: holds an entry, compares it and shifts from its neighbor.
module lkvc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvc_pkg::ctrl_t            ctrl,
	input  logic [lkvc_pkg::KEY_W-1:0] probe_key,
	input  lkvc_pkg::entry_t           prev,
	input  logic                       tail_in,
	output lkvc_pkg::entry_t           cur,
	output logic                       match,
	output logic                       tail_out
);
	import lkvc_pkg::*;

	logic                valid_q;
	logic                match_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   data_q;
	logic                shift;

	assign tail_out = match_q | tail_in;

	// On a hit every cell up to the hit cell moves one place back; on an
	// insert every valid cell moves back, dropping the last one when full.
	always_comb begin
		if (ctrl.any_hit) begin
			shift = ctrl.exec & tail_out;
		end else begin
			shift = ctrl.exec & ctrl.insert & prev.valid & (ctrl.room | valid_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.capture) begin
				match_q <= valid_q & (key_q == probe_key);
			end
			if (shift) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= prev.key;
			data_q <= prev.data;
		end
	end

	assign cur.valid = valid_q;
	assign cur.key   = key_q;
	assign cur.data  = data_q;
	assign match     = match_q;

endmodule

FILE: sim/lru_key_value_cache_unit_tb.sv
// Self-checking testbench of the LRU key/value cache: directed and random gets and puts.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	localparam int CACHE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} cache_access_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
	} cache_answer_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CAP_W-1:0]          cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      operation = 1'b0;
	logic signed [KEY_W-1:0]   key = '0;
	logic signed [DATA_W-1:0]  value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      hit;
	logic signed [DATA_W-1:0]  read_value;

	cache_access_t pending_accesses[$];
	cache_answer_t expected_answers[$];
	cache_access_t driven_access;
	cache_answer_t oldest_answer;

	logic [KEY_W-1:0]  line_key[CACHE_DEPTH];
	logic [DATA_W-1:0] line_data[CACHE_DEPTH];
	bit                line_valid[CACHE_DEPTH];
	int unsigned       line_rank[CACHE_DEPTH];
	int unsigned       lines_used;
	logic [CAP_W-1:0]  capacity_reg;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatches;
	int unsigned cycle_count;

	lru_key_value_cache_unit #(
		.ENTRIES(CACHE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.read_value(read_value)
	);

	function automatic int unsigned effective_capacity();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > CACHE_DEPTH)
			return CACHE_DEPTH;
		return 32'(capacity_reg);
	endfunction

	function automatic void promote_line(int unsigned slot, int unsigned limit);
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (line_valid[i] && i != slot && line_rank[i] < limit)
				line_rank[i]++;
		line_rank[slot] = 0;
	endfunction

	function automatic cache_answer_t predict_access(cache_access_t acc);
		cache_answer_t answer;
		int unsigned   slot;
		int unsigned   worst;
		bit            found;
		answer = '0;
		slot = 0;
		found = 1'b0;
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (!found && line_valid[i] && line_key[i] == acc.key) begin
				slot = i;
				found = 1'b1;
			end
		if (found) begin
			if (acc.op == OP_GET)
				answer.read_value = line_data[slot];
			else
				line_data[slot] = acc.value;
			promote_line(slot, line_rank[slot]);
		end else if (acc.op == OP_PUT) begin
			if (lines_used < effective_capacity()) begin
				for (int i = CACHE_DEPTH - 1; i >= 0; i--)
					if (!line_valid[i])
						slot = i;
				lines_used++;
			end else begin
				worst = 0;
				for (int i = 0; i < CACHE_DEPTH; i++)
					if (line_valid[i] && line_rank[i] >= worst) begin
						worst = line_rank[i];
						slot = i;
					end
			end
			line_valid[slot] = 1'b1;
			line_key[slot] = acc.key;
			line_data[slot] = acc.value;
			line_rank[slot] = CACHE_DEPTH;
			promote_line(slot, CACHE_DEPTH);
		end
		answer.hit = found;
		return answer;
	endfunction

	function automatic void note_mismatch(string field, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endfunction

	task automatic add_access(op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		cache_access_t acc;
		acc.op = op;
		acc.key = k;
		acc.value = v;
		pending_accesses.push_back(acc);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_accesses.size() != 0 || in_valid || expected_answers.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = cap;
	endtask

	task automatic random_burst(logic [CAP_W-1:0] cap, int unsigned idle_pct,
			int unsigned stall_pct, int unsigned count);
		logic [KEY_W-1:0] key_pool[$];
		int unsigned      pool_len;
		logic [KEY_W-1:0] k;
		write_capacity(cap);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		pool_len = effective_capacity() + $urandom_range(1, 6);
		for (int i = 0; i < pool_len; i++)
			key_pool.push_back($urandom());
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				k = $urandom();
			else
				k = key_pool[$urandom_range(pool_len - 1)];
			add_access($urandom_range(1) ? OP_PUT : OP_GET, k, $urandom());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_answers.push_back(predict_access(driven_access));
			if (!in_valid || in_ready) begin
				if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_access = pending_accesses.pop_front();
					in_valid <= 1'b1;
					operation <= driven_access.op;
					key <= driven_access.key;
					value <= driven_access.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: hit %b, read_value %h", hit, read_value);
			end else begin
				oldest_answer = expected_answers.pop_front();
				if (hit !== oldest_answer.hit)
					note_mismatch("hit", DATA_W'(oldest_answer.hit), DATA_W'(hit));
				if (read_value !== oldest_answer.read_value)
					note_mismatch("read_value", oldest_answer.read_value, read_value);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			line_key[i] = '0;
			line_data[i] = '0;
			line_valid[i] = 1'b0;
			line_rank[i] = 0;
		end
		lines_used = 0;
		capacity_reg = CAP_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
		add_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		add_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		add_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		add_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
		add_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		add_access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		add_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		add_access(OP_PUT, 32'h8000_0000, 32'h1234_5678);
		add_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
		add_access(OP_GET, 32'h0000_0001, 32'h0000_0000);

		// Capacity drops below the four entries in use; puts that miss must evict.
		write_capacity(5'd1);
		add_access(OP_PUT, 32'h0000_0005, 32'hAAAA_5555);
		add_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		add_access(OP_GET, 32'h0000_0005, 32'h0000_0000);
		add_access(OP_PUT, 32'h0000_0006, 32'h5555_AAAA);
		add_access(OP_GET, 32'h0000_0005, 32'h0000_0000);
		add_access(OP_GET, 32'h0000_0006, 32'h0000_0000);
		add_access(OP_PUT, 32'h0000_0006, 32'hFFFF_0000);
		add_access(OP_GET, 32'h0000_0006, 32'h0000_0000);

		random_burst(5'd16, 0, 0, 300);
		random_burst(5'd4, 76, 0, 300);
		random_burst(5'd0, 0, 76, 250);
		random_burst(5'd31, 33, 33, 300);
		random_burst(5'd1, 76, 76, 150);
		random_burst(5'd8, 0, 0, 250);
		random_burst(5'd17, 76, 0, 200);
		random_burst(5'd16, 33, 33, 250);

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
